### design/woa_pkg.sv
// Shared types and constants for the windowed on-time accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none
package woa_pkg;

  localparam int TIME_W          = 32;
  localparam int EVENT_DEPTH_DEF = 16;
  localparam logic [TIME_W-1:0] TIME_WINDOW_RST = 32'd86400;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // one ring entry
  typedef struct packed {
    logic              on;
    logic [TIME_W-1:0] t;
  } woa_entry_t;

  // sideband that travels with each ring read
  typedef struct packed {
    logic vld;
    logic last;
    logic written;
  } woa_tag_t;

endpackage
`default_nettype wire

### design/woa_ring.sv
// Event ring storage: one write port, one registered read port.
// Depends on woa_pkg.
`default_nettype none
module woa_ring
  import woa_pkg::*;
#(
  parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int AW          = $clog2(EVENT_DEPTH)
) (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [AW-1:0] waddr,
  input  wire woa_entry_t wdata,
  input  wire logic       re,
  input  wire logic [AW-1:0] raddr,
  output woa_entry_t      rdata
);

  woa_entry_t mem [EVENT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/woa_scan.sv
// Scan datapath: window test, on-interval accumulation, open-interval close.
// Depends on woa_pkg.
`default_nettype none
module woa_scan
  import woa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic [TIME_W-1:0] window,
  input  wire woa_tag_t          in_tag,
  input  wire woa_entry_t        in_entry,
  output logic                   res_done,
  output logic [TIME_W-1:0]      res
);

  logic [TIME_W-1:0] ent_t;
  logic              ent_on;
  logic [TIME_W-1:0] age;

  logic              a_vld;
  logic              a_last;
  logic [TIME_W-1:0] a_t;
  logic              a_on;
  logic              a_in;

  logic              running;
  logic [TIME_W-1:0] open_since;
  logic [TIME_W-1:0] total;
  logic              fin;

  // never-written slots read as time 0, off
  assign ent_t  = in_tag.written ? in_entry.t : '0;
  assign ent_on = in_tag.written & in_entry.on;
  assign age    = now - ent_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      a_last <= 1'b0;
    end else begin
      a_vld  <= in_tag.vld;
      a_last <= in_tag.vld & in_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    a_t  <= ent_t;
    a_on <= ent_on;
    a_in <= (age <= window);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      total   <= '0;
      fin     <= 1'b0;
    end else begin
      fin <= a_vld & a_last;
      if (start) begin
        running <= 1'b0;
        total   <= '0;
      end else if (a_vld && a_in) begin
        if (a_on) begin
          running    <= 1'b1;
          open_since <= a_t;
        end else if (running) begin
          total   <= total + a_t - open_since;
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_done <= 1'b0;
    end else begin
      res_done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res <= total + (running ? (now - open_since) : '0);
    end
  end

endmodule
`default_nettype wire

### design/windowed_on_time_accumulator.sv
// Top level: handshakes, ring pointers, scan sequencer, output register.
// Depends on woa_pkg, woa_ring, woa_scan.
//
// channel   dir  accept                        payload
// s_axis    in   s_axis_tvalid & s_axis_tready tuser: action; tdata: pump_on, now
// m_axis    out  m_axis_tvalid & m_axis_tready tdata: runtime
// cfg       in   cfg_valid & cfg_ready         cfg_data: time_window
//
// A sample leaves the sequencer in idle; the next item is accepted in the following cycle.
// A query reads the ring one entry per cycle over the single read port,
// then passes through the scan pipeline and the output load.
// Reset leaves the ring logically empty through a fill count; no clearing pass.
// A finished result waits in the output register while samples are accepted;
// a later query holds before its result load until that register is free.
`default_nettype none
module windowed_on_time_accumulator
  import woa_pkg::*;
#(
  parameter int EVENT_DEPTH = EVENT_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // [0] pump_on, [32:1] now, [39:33] zero
  input  wire logic [0:0]        s_axis_tuser,  // [0] action
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [TIME_W-1:0]      m_axis_tdata,  // [31:0] runtime
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TIME_W-1:0] cfg_data
);

  localparam int AW = $clog2(EVENT_DEPTH);
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(EVENT_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(EVENT_DEPTH);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    SCAN  = 4'b0010,
    DRAIN = 4'b0100,
    DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [AW-1:0]     write_slot;
  logic [CW-1:0]     fill;
  logic              last_status;
  logic [TIME_W-1:0] time_window;
  logic [TIME_W-1:0] qnow;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     rd_cnt;
  woa_tag_t          tag;

  logic              in_xfer;
  logic              in_action;
  logic              in_pump;
  logic [TIME_W-1:0] in_now;
  logic              sample_wr;
  logic              query_start;
  logic              rd_en;
  logic              out_free;
  woa_entry_t        wr_entry;
  woa_entry_t        rd_entry;
  logic              res_done;
  logic [TIME_W-1:0] res;

  assign in_action   = s_axis_tuser[0];
  assign in_pump     = s_axis_tdata[0];
  assign in_now      = s_axis_tdata[32:1];
  assign in_xfer     = s_axis_tvalid & s_axis_tready;
  assign sample_wr   = in_xfer & (in_action == ACT_SAMPLE) & (in_pump != last_status);
  assign query_start = in_xfer & (in_action == ACT_QUERY);
  assign rd_en       = (state == SCAN);
  assign out_free    = ~m_axis_tvalid | m_axis_tready;

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;

  assign wr_entry.on = in_pump;
  assign wr_entry.t  = in_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_window <= TIME_WINDOW_RST;
    end else if (cfg_valid) begin
      time_window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      fill        <= '0;
      last_status <= 1'b0;
    end else if (sample_wr) begin
      write_slot  <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      last_status <= in_pump;
      if (fill != FULL_CNT) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      qnow <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      rd_ptr <= '0;
      rd_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (query_start) begin
            rd_ptr <= write_slot;
            rd_cnt <= '0;
            state  <= SCAN;
          end
        end
        SCAN: begin
          rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == LAST_SLOT) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (res_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // tag lines up with the registered ring read
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag.vld     <= rd_en;
      tag.last    <= (rd_cnt == LAST_SLOT);
      tag.written <= (CW'(rd_ptr) < fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == DONE) && out_free) begin
      m_axis_tdata <= res;
    end
  end

  woa_ring #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .AW          (AW)
  ) u_ring (
    .clk   (clk),
    .we    (sample_wr),
    .waddr (write_slot),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_ptr),
    .rdata (rd_entry)
  );

  woa_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (query_start),
    .now      (qnow),
    .window   (time_window),
    .in_tag   (tag),
    .in_entry (rd_entry),
    .res_done (res_done),
    .res      (res)
  );

endmodule
`default_nettype wire

### sim/tb_windowed_on_time_accumulator.sv
// Testbench for windowed_on_time_accumulator: directed and random sample/query traffic
// checked against an in-bench model of the event ring and the windowed on-time scan.
// Depends on woa_pkg and the design sources; needs no files or arguments.
`timescale 1ns / 100ps
module tb_windowed_on_time_accumulator;
  import woa_pkg::*;

  localparam int DEPTH = EVENT_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // [0] pump_on, [32:1] now, [39:33] zero
  logic [0:0]        s_axis_tuser = '0;   // [0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TIME_W-1:0] m_axis_tdata;        // [31:0] runtime
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data = '0;

  windowed_on_time_accumulator #(.EVENT_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // model of the block state
  logic [TIME_W-1:0] ring_time [DEPTH];
  logic              ring_on [DEPTH];
  int unsigned       ring_wr = 0;
  logic              prev_status = 1'b0;
  logic [TIME_W-1:0] window_q = TIME_WINDOW_RST;

  logic [TIME_W-1:0] runtime_q [$];
  int unsigned       fail_count = 0;
  int unsigned       reports = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       burst_left = 0;
  int unsigned       hold_req = 0;
  int unsigned       hold_left = 0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_phase = 0;
  int unsigned       rx_tick = 0;

  function automatic logic [TIME_W-1:0] on_time_in_window(input logic [TIME_W-1:0] tnow);
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] age;
    logic              busy;
    int unsigned       slot;
    total = '0;
    since = '0;
    busy  = 1'b0;
    slot  = ring_wr;
    for (int n = 0; n < DEPTH; n++) begin
      age = tnow - ring_time[slot];
      if (age <= window_q) begin
        if (ring_on[slot]) begin
          busy  = 1'b1;
          since = ring_time[slot];
        end else if (busy) begin
          total = total + (ring_time[slot] - since);
          busy  = 1'b0;
        end
      end
      slot = (slot + 1) % DEPTH;
    end
    if (busy) total = total + (tnow - since);
    return total;
  endfunction

  // one input transfer; returns at the falling edge after acceptance with tvalid still high
  task automatic send_item(input logic act, input logic pump, input logic [TIME_W-1:0] tnow);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, tnow, pump};
    do @(posedge clk); while (!s_axis_tready);
    if (act == ACT_QUERY) begin
      runtime_q.push_back(on_time_in_window(tnow));
    end else if (pump != prev_status) begin
      ring_time[ring_wr] = tnow;
      ring_on[ring_wr]   = pump;
      ring_wr            = (ring_wr + 1) % DEPTH;
      prev_status        = pump;
    end
    @(negedge clk);
  endtask

  // sender bursts with random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  task automatic send(input logic act, input logic pump, input logic [TIME_W-1:0] tnow);
    send_item(act, pump, tnow);
    pace();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (runtime_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_time_window(input logic [TIME_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    window_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send(ACT_QUERY, 1'b0, 32'h0000_0000);
    send(ACT_QUERY, 1'b1, 32'hFFFF_FFFF);
  endtask

  // on/off intervals, repeated status, pump bit ignored on a query
  task automatic test_basic_intervals();
    send(ACT_SAMPLE, 1'b1, 32'd100);
    send(ACT_SAMPLE, 1'b1, 32'd120);
    send(ACT_SAMPLE, 1'b0, 32'd150);
    send(ACT_SAMPLE, 1'b0, 32'd160);
    send(ACT_SAMPLE, 1'b1, 32'd200);
    send(ACT_QUERY,  1'b1, 32'd250);
  endtask

  task automatic test_time_wrap();
    send(ACT_SAMPLE, 1'b0, 32'hFFFF_FFF0);
    send(ACT_SAMPLE, 1'b1, 32'hFFFF_FFF8);
    send(ACT_QUERY,  1'b0, 32'h0000_0008);
  endtask

  task automatic test_window_extremes();
    write_time_window(32'h0000_0000);
    send(ACT_QUERY, 1'b0, 32'hFFFF_FFF8);
    write_time_window(32'hFFFF_FFFF);
    send(ACT_QUERY, 1'b1, 32'h7FFF_FFFF);
  endtask

  // enough status changes to wrap the ring
  task automatic test_ring_wrap();
    for (int k = 0; k < 12; k++) send(ACT_SAMPLE, ~prev_status, 32'd5000 + 32'(k * 7));
    send(ACT_QUERY, 1'b0, 32'd5100);
  endtask

  // long receiver hold while queries keep coming, then a full drain
  task automatic test_backpressure();
    drain();
    @(posedge clk);
    hold_req = 400;
    @(negedge clk);
    for (int k = 0; k < 14; k++) begin
      if (k % 3 == 1) send_item(ACT_SAMPLE, ~prev_status, 32'd9000 + 32'(k));
      else send_item(ACT_QUERY, k[0], 32'd9000 + 32'(k));
    end
    drain();
  endtask

  task automatic test_random_traffic(input int n, input logic [TIME_W-1:0] start,
                                     input int unsigned step_max);
    logic [TIME_W-1:0] tbase;
    int unsigned       r;
    tbase = start;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        tbase = tbase + $urandom_range(0, step_max);
        if (r < 40) send(ACT_QUERY, 1'($urandom_range(0, 1)), tbase);
        else if (r < 80) send(ACT_SAMPLE, ~prev_status, tbase);
        else send(ACT_SAMPLE, prev_status, tbase);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_time[i] = '0;
      ring_on[i]   = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_contents();
    test_basic_intervals();
    test_time_wrap();
    test_window_extremes();
    test_ring_wrap();
    test_backpressure();

    write_time_window(TIME_WINDOW_RST);
    test_random_traffic(120, 32'hFFFF_F000, 3000);
    write_time_window($urandom_range(20, 400));
    test_random_traffic(150, $urandom, 60);
    write_time_window(32'h0000_0000);
    test_random_traffic(60, $urandom, 1);
    write_time_window(32'hFFFF_FFFF);
    test_random_traffic(80, $urandom, 32'h0010_0000);
    write_time_window($urandom);
    test_random_traffic(100, $urandom, 32'hFFFF_FFFF);

    drain();
    if (fail_count == 0 && runtime_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    logic [TIME_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (runtime_q.size() == 0) begin
        fail_count++;
        if (reports < 10) begin
          reports++;
          $display("unexpected result transfer: runtime %0d", m_axis_tdata);
        end
      end else begin
        want = runtime_q.pop_front();
        if (m_axis_tdata !== want) begin
          fail_count++;
          if (reports < 10) begin
            reports++;
            $display("runtime mismatch: expected %0d got %0d", want, m_axis_tdata);
          end
        end
      end
    end
  end

  // long hold-off counter
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req  <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern: phases of always-ready, random, and periodic stalls
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_phase == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_phase <= $urandom_range(20, 120);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    if (hold_left != 0) m_axis_tready <= 1'b0;
    else case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= (rx_tick % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
